@@ hw/rtl/mdrc_pkg.sv @@
// Shared types, constants and helper functions for the motor duty ramp controller.
// No dependencies; every other file refers to this package by scoped names.
package mdrc_pkg;

    // Field widths
    localparam int MOTOR_W    = 3;
    localparam int DUTY_W     = 15;
    localparam int VALUE_W    = 16;
    localparam int TOP_W      = 16;
    localparam int INTERVAL_W = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;

    // Default motor count
    localparam int MOTORS_DEF = 4;

    // Full scale duty (100 percent in 1/256 percent units)
    localparam logic [DUTY_W-1:0] FULL_DUTY = 15'd25600;

    // Register reset values
    localparam logic [DUTY_W-1:0]     RST_DUTY_MIN      = 15'd0;
    localparam logic [DUTY_W-1:0]     RST_DUTY_MAX      = 15'd25600;
    localparam logic [DUTY_W-1:0]     RST_ARMED_DUTY    = 15'd1280;
    localparam logic [DUTY_W-1:0]     RST_DISARMED_DUTY = 15'd0;
    localparam logic [TOP_W-1:0]      RST_COMPARE_TOP   = 16'd4199;
    localparam logic [INTERVAL_W-1:0] RST_RAMP_INTERVAL = 8'd10;

    // Compare scaling: duty*top/25600 = ((duty*top) >> 8) / 100,
    // the divide by 100 done as a multiply by ceil(2^30/100) and a shift.
    localparam int P1_W         = DUTY_W + TOP_W;   // 31
    localparam int P1_SHIFT     = 8;
    localparam int QUOT_W       = P1_W - P1_SHIFT;  // 23
    localparam int RECIP_W      = 24;
    localparam int RECIP_SHIFT  = 30;
    localparam int P2_W         = QUOT_W + RECIP_W; // 47
    localparam logic [RECIP_W-1:0] RECIP_K = 24'd10737419;

    // Operation codes
    typedef enum logic [2:0] {
        OP_SET    = 3'd0,
        OP_ADJUST = 3'd1,
        OP_RAMP   = 3'd2,
        OP_TICK   = 3'd3,
        OP_ARM    = 3'd4,
        OP_DISARM = 3'd5,
        OP_QUERY  = 3'd6,
        OP_NONE   = 3'd7
    } t_op;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DUTY_MIN      = 3'd0,
        CFG_DUTY_MAX      = 3'd1,
        CFG_ARMED_DUTY    = 3'd2,
        CFG_DISARMED_DUTY = 3'd3,
        CFG_COMPARE_TOP   = 3'd4,
        CFG_RAMP_INTERVAL = 3'd5
    } t_cfg_idx;

    // Commands from the sequencer to the datapath
    typedef struct packed {
        logic               cap;   // latch the accepted item
        logic               exec;  // apply the update for the current motor
        logic               mul1;  // read duty, first compare product
        logic               mul2;  // reciprocal product
        logic               load;  // load the output register
        logic               all;   // item walks all motors
        logic               last;  // current result is the final one
        logic [MOTOR_W-1:0] idx;   // motor being walked
    } t_ctrl;

    // Limit a value to full scale
    function automatic logic [DUTY_W-1:0] cap_full(input logic [DUTY_W-1:0] v);
        return (v > FULL_DUTY) ? FULL_DUTY : v;
    endfunction

    // Clamp into [lo, hi], lower bound first, then never below zero
    function automatic logic [DUTY_W-1:0] clamp_duty(
        input logic signed [DUTY_W+1:0] v,
        input logic [DUTY_W-1:0]        lo,
        input logic [DUTY_W-1:0]        hi
    );
        logic signed [DUTY_W+1:0] t;
        t = v;
        if (t < $signed({2'b00, lo})) t = $signed({2'b00, lo});
        if (t > $signed({2'b00, hi})) t = $signed({2'b00, hi});
        if (t < 0) t = '0;
        return t[DUTY_W-1:0];
    endfunction

endpackage

@@ hw/rtl/mdrc_ctrl.sv @@
// Sequencer of the motor duty ramp controller: one-hot state machine and motor counter.
// Depends on mdrc_pkg; drives the datapath through mdrc_pkg::t_ctrl.
module mdrc_ctrl #(
    parameter int MOTORS = mdrc_pkg::MOTORS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    input  mdrc_pkg::t_op        i_op,
    input  logic                 i_slot_free,
    output logic                 o_s_tready,
    output mdrc_pkg::t_ctrl      o_ctrl
);

    localparam int IW = (MOTORS > 1) ? $clog2(MOTORS) : 1;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_MUL1 = 5'b00100,
        S_MUL2 = 5'b01000,
        S_LOAD = 5'b10000
    } t_state;

    t_state        r_state, n_state;
    logic [IW-1:0] r_idx, n_idx;
    logic          r_all, n_all;
    logic          last;
    logic          accept;

    assign accept = i_s_tvalid && (r_state == S_IDLE);
    assign last   = !r_all || (r_idx == IW'(MOTORS - 1));

    // Next state and counter
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_all   = r_all;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_op != mdrc_pkg::OP_NONE)) begin
                    n_state = S_EXEC;
                    n_idx   = '0;
                    n_all   = (i_op == mdrc_pkg::OP_TICK) || (i_op == mdrc_pkg::OP_ARM) ||
                              (i_op == mdrc_pkg::OP_DISARM);
                end
            end
            S_EXEC: n_state = S_MUL1;
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_LOAD;
            S_LOAD: begin
                if (i_slot_free) begin
                    if (last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_EXEC;
                        n_idx   = r_idx + IW'(1);
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_all   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_all   <= n_all;
        end
    end

    // Commands
    assign o_s_tready  = (r_state == S_IDLE);
    assign o_ctrl.cap  = accept && (i_op != mdrc_pkg::OP_NONE);
    assign o_ctrl.exec = (r_state == S_EXEC);
    assign o_ctrl.mul1 = (r_state == S_MUL1);
    assign o_ctrl.mul2 = (r_state == S_MUL2);
    assign o_ctrl.load = (r_state == S_LOAD) && i_slot_free;
    assign o_ctrl.all  = r_all;
    assign o_ctrl.last = last;
    assign o_ctrl.idx  = mdrc_pkg::MOTOR_W'(r_idx);

endmodule

@@ hw/rtl/mdrc_dp.sv @@
// Datapath of the motor duty ramp controller: registers, per-motor state,
// clamp and ramp arithmetic, compare multiplier and output register. Depends on mdrc_pkg.
module mdrc_dp #(
    parameter int MOTORS = mdrc_pkg::MOTORS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mdrc_pkg::t_ctrl                     i_ctrl,
    input  mdrc_pkg::t_op                       i_op,
    input  logic [mdrc_pkg::IN_DATA_W-1:0]      i_in_data,
    input  logic                                i_cfg_we,
    input  mdrc_pkg::t_cfg_idx                  i_cfg_index,
    input  logic [mdrc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_m_tready,
    output logic                                o_slot_free,
    output logic                                o_m_tvalid,
    output logic [mdrc_pkg::OUT_DATA_W-1:0]     o_m_tdata,
    output logic                                o_m_tuser,
    output logic                                o_m_tlast
);

    localparam int IW = (MOTORS > 1) ? $clog2(MOTORS) : 1;
    localparam int DW = mdrc_pkg::DUTY_W;
    localparam int MW = mdrc_pkg::MOTOR_W;

    // Configuration registers
    logic [DW-1:0]                      r_duty_min, r_duty_max, r_armed_duty, r_disarmed_duty;
    logic [mdrc_pkg::TOP_W-1:0]         r_compare_top;
    logic [mdrc_pkg::INTERVAL_W-1:0]    r_ramp_interval;

    // Per-motor state
    logic [DW-1:0] r_duty   [MOTORS];
    logic [DW-1:0] r_target [MOTORS];
    logic [DW-1:0] r_incr   [MOTORS];
    logic          r_active [MOTORS];
    logic                               r_armed;
    logic [mdrc_pkg::INTERVAL_W-1:0]    r_cnt;
    logic                               r_step_now;

    // Latched item
    mdrc_pkg::t_op                      r_op;
    logic [MW-1:0]                      r_motor;
    logic signed [mdrc_pkg::VALUE_W-1:0] r_value;
    logic [DW-1:0]                      r_step;

    // Result pipeline
    logic [DW-1:0]                      r_rep_duty;
    logic [MW-1:0]                      r_rep_motor;
    logic                               r_rep_rej;
    logic [mdrc_pkg::P1_W-1:0]          r_p1;
    logic [mdrc_pkg::P2_W-1:0]          r_p2;

    // Output register
    logic                               r_out_valid;
    logic [mdrc_pkg::OUT_DATA_W-1:0]    r_out_data;
    logic                               r_out_rej;
    logic                               r_out_last;

    // Derived values
    logic [IW-1:0]                      sel;
    logic                               rej;
    logic [DW-1:0]                      lo, hi, cur, tgt, stp, rd_duty;
    logic signed [DW+1:0]               cur_s, tgt_s, stp_s, val_s, up_s, dn_s, ramp_nxt;
    logic [DW-1:0]                      set_duty, adj_duty, ramp_duty, new_target;
    logic [mdrc_pkg::INTERVAL_W-1:0]    cnt_inc, lim;
    logic [DW-1:0]                      in_step;
    logic [mdrc_pkg::TOP_W-1:0]         cmp;

    assign sel = i_ctrl.all ? i_ctrl.idx[IW-1:0] : r_motor[IW-1:0];
    assign rej = !i_ctrl.all && ({1'b0, r_motor} >= (MW + 1)'(MOTORS));
    assign lo  = mdrc_pkg::cap_full(r_duty_min);
    assign hi  = mdrc_pkg::cap_full(r_duty_max);
    assign cur = r_duty[sel];
    assign tgt = r_target[sel];
    assign stp = r_incr[sel];

    // Set, adjust and ramp arithmetic
    assign cur_s      = $signed({2'b00, cur});
    assign tgt_s      = $signed({2'b00, tgt});
    assign stp_s      = $signed({2'b00, stp});
    assign val_s      = $signed({r_value[mdrc_pkg::VALUE_W-1], r_value});
    assign set_duty   = mdrc_pkg::clamp_duty(val_s, lo, hi);
    assign adj_duty   = mdrc_pkg::clamp_duty(cur_s + val_s, lo, hi);
    assign new_target = set_duty;
    assign up_s       = cur_s + stp_s;
    assign dn_s       = cur_s - stp_s;
    always_comb begin
        if (cur_s < tgt_s) begin
            ramp_nxt = (up_s > tgt_s) ? tgt_s : up_s;
        end else begin
            ramp_nxt = (dn_s < tgt_s) ? tgt_s : dn_s;
        end
    end
    assign ramp_duty = mdrc_pkg::clamp_duty(ramp_nxt, lo, hi);

    // Tick timebase
    assign cnt_inc = r_cnt + mdrc_pkg::INTERVAL_W'(1);
    assign lim     = (r_ramp_interval == '0) ? mdrc_pkg::INTERVAL_W'(1) : r_ramp_interval;
    assign in_step = i_in_data[33:19];

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty_min      <= mdrc_pkg::RST_DUTY_MIN;
            r_duty_max      <= mdrc_pkg::RST_DUTY_MAX;
            r_armed_duty    <= mdrc_pkg::RST_ARMED_DUTY;
            r_disarmed_duty <= mdrc_pkg::RST_DISARMED_DUTY;
            r_compare_top   <= mdrc_pkg::RST_COMPARE_TOP;
            r_ramp_interval <= mdrc_pkg::RST_RAMP_INTERVAL;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mdrc_pkg::CFG_DUTY_MIN:      r_duty_min      <= i_cfg_data[DW-1:0];
                mdrc_pkg::CFG_DUTY_MAX:      r_duty_max      <= i_cfg_data[DW-1:0];
                mdrc_pkg::CFG_ARMED_DUTY:    r_armed_duty    <= i_cfg_data[DW-1:0];
                mdrc_pkg::CFG_DISARMED_DUTY: r_disarmed_duty <= i_cfg_data[DW-1:0];
                mdrc_pkg::CFG_COMPARE_TOP:   r_compare_top   <= i_cfg_data;
                mdrc_pkg::CFG_RAMP_INTERVAL:
                    r_ramp_interval <= i_cfg_data[mdrc_pkg::INTERVAL_W-1:0];
                default: ;
            endcase
        end
    end

    // Latch the accepted item
    always_ff @(posedge i_clk) begin
        if (i_ctrl.cap) begin
            r_op    <= i_op;
            r_motor <= i_in_data[2:0];
            r_value <= $signed(i_in_data[18:3]);
            r_step  <= in_step;
        end
    end

    // Motor state: broadcast updates on accept, per-motor updates on exec
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MOTORS; i++) begin
                r_duty[i]   <= '0;
                r_target[i] <= '0;
                r_incr[i]   <= '0;
                r_active[i] <= 1'b0;
            end
            r_armed    <= 1'b0;
            r_cnt      <= '0;
            r_step_now <= 1'b0;
        end else if (i_ctrl.cap) begin
            case (i_op) inside
                mdrc_pkg::OP_TICK: begin
                    if (cnt_inc >= lim) begin
                        r_cnt      <= '0;
                        r_step_now <= 1'b1;
                    end else begin
                        r_cnt      <= cnt_inc;
                        r_step_now <= 1'b0;
                    end
                end
                mdrc_pkg::OP_ARM, mdrc_pkg::OP_DISARM: begin
                    r_armed <= (i_op == mdrc_pkg::OP_ARM);
                    for (int i = 0; i < MOTORS; i++) begin
                        r_duty[i]   <= mdrc_pkg::cap_full((i_op == mdrc_pkg::OP_ARM) ?
                                                          r_armed_duty : r_disarmed_duty);
                        r_active[i] <= 1'b0;
                    end
                end
                default: ;
            endcase
        end else if (i_ctrl.exec && !rej) begin
            case (r_op)
                mdrc_pkg::OP_SET: begin
                    r_duty[sel]   <= set_duty;
                    r_active[sel] <= 1'b0;
                end
                mdrc_pkg::OP_ADJUST: begin
                    r_duty[sel]   <= adj_duty;
                    r_active[sel] <= 1'b0;
                end
                mdrc_pkg::OP_RAMP: begin
                    r_target[sel] <= new_target;
                    r_incr[sel]   <= (r_step == '0) ? DW'(1) : r_step;
                    r_active[sel] <= (cur != new_target);
                end
                mdrc_pkg::OP_TICK: begin
                    if (r_step_now && r_active[sel]) begin
                        r_duty[sel] <= ramp_duty;
                        if (ramp_nxt == tgt_s) r_active[sel] <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Compare value: two registered multiplies
    assign rd_duty = rej ? '0 : cur;
    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul1) begin
            r_rep_duty  <= rd_duty;
            r_rep_rej   <= rej;
            r_rep_motor <= i_ctrl.all ? i_ctrl.idx : r_motor;
            r_p1        <= mdrc_pkg::P1_W'(rd_duty) * mdrc_pkg::P1_W'(r_compare_top);
        end
        if (i_ctrl.mul2) begin
            r_p2 <= mdrc_pkg::P2_W'(r_p1[mdrc_pkg::P1_W-1:mdrc_pkg::P1_SHIFT]) *
                    mdrc_pkg::P2_W'(mdrc_pkg::RECIP_K);
        end
    end
    assign cmp = r_p2[mdrc_pkg::RECIP_SHIFT +: mdrc_pkg::TOP_W];

    // Output register: holds a result until the transfer
    assign o_slot_free = !r_out_valid || i_m_tready;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_out_data <= {5'b0, r_armed, cmp, r_rep_duty, r_rep_motor};
            r_out_rej  <= r_rep_rej;
            r_out_last <= i_ctrl.last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_rej;
    assign o_m_tlast  = r_out_last;

endmodule

@@ hw/rtl/motor_duty_ramp_controller.sv @@
// Motor duty ramp controller, top level: stream ports, configuration write port,
// sequencer (mdrc_ctrl) and datapath (mdrc_dp). Depends on mdrc_pkg.
//
// Keeps one duty per motor (25600 = 100 percent) and answers each command with
// result transfers that carry the duty and its PWM compare value
// duty*compare_top/25600. Set, adjust, ramp start and query give one result;
// tick, arm and disarm give one result per motor, motor 0 first, with tlast on
// the final one. Unknown operation code 7 is taken and dropped. A command is
// taken only while the sequencer is idle: it walks one motor for a single-motor
// command and every motor for a tick, arm or disarm, each through update, two
// registered compare multiplies and output load, which waits on a free output slot.
// The output register lets the next command be taken while the final result of
// the previous one still waits on tready. Configuration is always ready and
// should be written only while no command is in flight.
module motor_duty_ramp_controller #(
    parameter int MOTORS = mdrc_pkg::MOTORS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Command stream
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [mdrc_pkg::IN_DATA_W-1:0]      i_s_tdata,  // motor[2:0], value[18:3],
                                                            // ramp_step[33:19], zero pad
    input  logic [2:0]                          i_s_tuser,  // operation[2:0]
    // Result stream
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [mdrc_pkg::OUT_DATA_W-1:0]     o_m_tdata,  // motor_out[2:0], duty_out[17:3],
                                                            // compare_out[33:18],
                                                            // armed_out[34], zero pad
    output logic                                o_m_tuser,  // rejected
    output logic                                o_m_tlast,  // last
    // Configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mdrc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mdrc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    mdrc_pkg::t_ctrl ctrl;
    mdrc_pkg::t_op   op;
    logic            slot_free;

    assign op          = mdrc_pkg::t_op'(i_s_tuser);
    assign o_cfg_ready = 1'b1;

    // Sequencer
    mdrc_ctrl #(
        .MOTORS (MOTORS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .i_op        (op),
        .i_slot_free (slot_free),
        .o_s_tready  (o_s_tready),
        .o_ctrl      (ctrl)
    );

    // Datapath
    mdrc_dp #(
        .MOTORS (MOTORS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .i_op        (op),
        .i_in_data   (i_s_tdata),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (mdrc_pkg::t_cfg_idx'(i_cfg_index)),
        .i_cfg_data  (i_cfg_data),
        .i_m_tready  (i_m_tready),
        .o_slot_free (slot_free),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

endmodule
